FILE: src/volume_central_difference_gradient_macros.svh
// assertion helpers shared by the rtl files
`ifndef VOLUME_CENTRAL_DIFFERENCE_GRADIENT_MACROS_SVH
`define VOLUME_CENTRAL_DIFFERENCE_GRADIENT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition in the cycle after a trigger
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/vcdg_pkg.sv
`default_nettype none
package vcdg_pkg;

    // address field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 7;
    localparam int SLC_W  = 2;
    localparam int ADDR_W = SLC_W + ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam int MAX_WIDTH  = 1 << COL_W;
    localparam int MAX_HEIGHT = 1 << ROW_W;
    localparam int MAX_SLICES = 1 << SLC_W;

    localparam int PIX_W  = 16;
    localparam int ACC_W  = 17;
    localparam int DIM_W  = 8;
    localparam int SC_W   = 3;
    localparam int STEP_W = 6;

    localparam logic [ACC_W-1:0] TERM_LIMIT = 17'd32767;

    localparam logic [2:0] AXIS_X = 3'h1;
    localparam logic [2:0] AXIS_Y = 3'h2;
    localparam logic [2:0] AXIS_Z = 3'h4;

    // divider sizes
    localparam int DIV_NUM_W = 36;
    localparam int DIV_DEN_W = 18;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [1:0] {
        REQ_LOAD,
        REQ_COMPUTE,
        REQ_READ,
        REQ_NONE
    } req_kind_t;

    // register indexes
    localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_SLICE_COUNT    = 3'd2;
    localparam logic [2:0] CFG_AXIS_MASK      = 3'd3;
    localparam logic [2:0] CFG_STEP_DISTANCE  = 3'd4;
    localparam logic [2:0] CFG_RESCALE_ENABLE = 3'd5;
    localparam logic [2:0] CFG_OUT_MIN        = 3'd6;
    localparam logic [2:0] CFG_OUT_MAX        = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]        image_width;
        logic [DIM_W-1:0]        image_height;
        logic [SC_W-1:0]         slice_count;
        logic [2:0]              axis_mask;
        logic [STEP_W-1:0]       step_distance;
        logic                    rescale_enable;
        logic signed [PIX_W-1:0] out_min;
        logic signed [PIX_W-1:0] out_max;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        req_kind_t        kind;
        logic [SLC_W-1:0] slice_index;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] pixel_value;
    } eng_req_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] value;
    } eng_resp_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
        logic [DIV_DEN_W-1:0] rem;
    } div_resp_t;

endpackage
`default_nettype wire

FILE: src/vcdg_divider.sv
`default_nettype none
module vcdg_divider
    import vcdg_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire div_req_t  div_req,
    output div_resp_t      div_resp
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W:0]   rem_next;

    // one restoring step per cycle
    always_comb begin
        trial    = {rem_reg, num_reg[DIV_NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? trial - {1'b0, den_reg} : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= div_req.num;
                den_reg  <= div_req.den;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next[DIV_DEN_W-1:0];
                num_reg <= {num_reg[DIV_NUM_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign div_resp.done = done_reg;
    assign div_resp.quot = num_reg;
    assign div_resp.rem  = rem_reg;

endmodule
`default_nettype wire

FILE: src/vcdg_engine.sv
`default_nettype none
`include "volume_central_difference_gradient_macros.svh"
module vcdg_engine
    import vcdg_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t     cfg,
    input  wire eng_req_t req,
    output logic          ready,
    output eng_resp_t     resp
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_ACC_RD,
        ST_ACC_ADD,
        ST_SLICE,
        ST_MM_RD,
        ST_MM_CMP,
        ST_OUT_RD,
        ST_OUT_MUL,
        ST_OUT_DIV,
        ST_OUT_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg;

    // storage
    logic [PIX_W-1:0] vol_mem  [DEPTH];
    logic [ACC_W-1:0] grad_mem [DEPTH];

    logic [ADDR_W-1:0] cnt_reg;
    logic [1:0]        axis_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              term_en_reg;
    logic [SC_W-1:0]   slice_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic              first_reg;
    logic [ACC_W-1:0]  lo_reg;
    logic [ACC_W-1:0]  hi_reg;
    logic [ACC_W-1:0]  v_reg;
    logic signed [34:0] prod_reg;
    logic              neg_reg;

    logic [PIX_W-1:0]  vol_a_reg;
    logic [PIX_W-1:0]  vol_b_reg;
    logic [ACC_W-1:0]  grad_rd_reg;

    logic [ADDR_W-1:0] vol_ra_a;
    logic [ADDR_W-1:0] vol_ra_b;
    logic [ADDR_W-1:0] grad_ra;
    logic              grad_we;
    logic [ADDR_W-1:0] grad_wa;
    logic [ACC_W-1:0]  grad_wd;

    div_req_t  div_req;
    div_resp_t div_resp;

    // limited geometry and axis count
    logic [DIM_W-1:0] w_lim;
    logic [DIM_W-1:0] h_lim;
    logic [SC_W-1:0]  sc_lim;
    logic [1:0]       n_axes;
    logic [1:0]       n_div;

    always_comb begin
        w_lim  = (cfg.image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg.image_width;
        h_lim  = (cfg.image_height > DIM_W'(MAX_HEIGHT)) ?
                 DIM_W'(MAX_HEIGHT) : cfg.image_height;
        sc_lim = (cfg.slice_count > SC_W'(MAX_SLICES)) ? SC_W'(MAX_SLICES) : cfg.slice_count;
        n_axes = {1'b0, cfg.axis_mask[0]} + {1'b0, cfg.axis_mask[1]}
               + {1'b0, cfg.axis_mask[2]};
        n_div  = (n_axes == 2'd0) ? 2'd1 : n_axes;
    end

    // neighbour addressing for the accumulate pass
    logic [SLC_W-1:0] cs;
    logic [ROW_W-1:0] cr;
    logic [COL_W-1:0] cc;
    logic             in_range;
    logic             x_ok;
    logic             y_ok;
    logic             z_ok;
    logic             axis_ok;
    logic [STEP_W-1:0] d;

    always_comb begin
        d      = cfg.step_distance;
        cc     = cnt_reg[COL_W-1:0];
        cr     = cnt_reg[COL_W+ROW_W-1:COL_W];
        cs     = cnt_reg[ADDR_W-1:COL_W+ROW_W];
        in_range = ({1'b0, cs} < sc_lim) && ({1'b0, cr} < h_lim) && ({1'b0, cc} < w_lim);
        x_ok   = ((cfg.axis_mask & AXIS_X) != 3'd0) && in_range
              && ({1'b0, cc} >= {2'b0, d}) && (({1'b0, cc} + {2'b0, d}) < w_lim);
        y_ok   = ((cfg.axis_mask & AXIS_Y) != 3'd0) && in_range
              && ({1'b0, cr} >= {2'b0, d}) && (({1'b0, cr} + {2'b0, d}) < h_lim);
        z_ok   = ((cfg.axis_mask & AXIS_Z) != 3'd0) && in_range
              && ({4'b0, cs} >= d)
              && (({5'b0, cs} + {1'b0, d}) < {4'b0, sc_lim});
        unique case (axis_reg)
            2'd0: begin
                axis_ok  = x_ok;
                vol_ra_a = {cs, cr, cc + COL_W'(d)};
                vol_ra_b = {cs, cr, cc - COL_W'(d)};
            end
            2'd1: begin
                axis_ok  = y_ok;
                vol_ra_a = {cs, cr + ROW_W'(d), cc};
                vol_ra_b = {cs, cr - ROW_W'(d), cc};
            end
            default: begin
                axis_ok  = z_ok;
                vol_ra_a = {cs + d[SLC_W-1:0], cr, cc};
                vol_ra_b = {cs - d[SLC_W-1:0], cr, cc};
            end
        endcase
    end

    // clamped absolute difference and running sum
    logic signed [PIX_W:0] diff;
    logic [ACC_W-1:0]      absd;
    logic [ACC_W-1:0]      term;
    logic [ACC_W-1:0]      acc_sum;

    always_comb begin
        diff    = $signed({vol_a_reg[PIX_W-1], vol_a_reg})
                - $signed({vol_b_reg[PIX_W-1], vol_b_reg});
        absd    = diff[PIX_W] ? ACC_W'(-diff) : ACC_W'(diff);
        term    = (absd > TERM_LIMIT) ? TERM_LIMIT : absd;
        acc_sum = acc_reg + (term_en_reg ? term : '0);
    end

    // slice walk for min/max and final values
    logic [ADDR_W-1:0] p2_addr;
    logic              col_last;
    logic              row_last;
    logic              pass_end;
    logic [ACC_W-1:0]  span;
    logic              flat;

    always_comb begin
        p2_addr  = {slice_reg[SLC_W-1:0], row_reg, col_reg};
        col_last = ({1'b0, col_reg} + 8'd1) == w_lim;
        row_last = ({1'b0, row_reg} + 8'd1) == h_lim;
        pass_end = col_last && row_last;
        span     = hi_reg - lo_reg;
        flat     = cfg.rescale_enable && (hi_reg == lo_reg);
    end

    // rescale multiply operands
    logic signed [ACC_W-1:0] out_span;
    logic signed [ACC_W:0]   dv;
    logic signed [34:0]      prod_next;

    always_comb begin
        out_span  = $signed({cfg.out_max[PIX_W-1], cfg.out_max})
                  - $signed({cfg.out_min[PIX_W-1], cfg.out_min});
        dv        = $signed({1'b0, grad_rd_reg - lo_reg});
        prod_next = out_span * dv;
    end

    // divider operands
    logic [36:0]      num_r;
    logic             num_neg;
    logic [36:0]      num_mag;
    logic [18:0]      num_p;

    always_comb begin
        num_r   = {prod_reg[34], prod_reg, 1'b0} + {20'd0, span};
        num_p   = {1'b0, v_reg, 1'b0} + {17'd0, n_div};
        num_neg = cfg.rescale_enable && num_r[36];
        num_mag = num_r[36] ? (~num_r + 37'd1) : num_r;
        div_req.start = (state_reg == ST_OUT_DIV) && !flat;
        if (cfg.rescale_enable) begin
            div_req.num = num_mag[DIV_NUM_W-1:0];
            div_req.den = {span, 1'b0};
        end else begin
            div_req.num = {17'd0, num_p};
            div_req.den = {15'd0, n_div, 1'b0};
        end
    end

    vcdg_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .div_req  (div_req),
        .div_resp (div_resp)
    );

    // floor correction and offset
    logic [DIV_NUM_W-1:0] qf;
    logic [PIX_W-1:0]     base;
    logic [PIX_W-1:0]     res;

    always_comb begin
        qf   = div_resp.quot + {35'd0, (neg_reg && (div_resp.rem != '0))};
        base = cfg.rescale_enable ? cfg.out_min : '0;
        res  = neg_reg ? base - qf[PIX_W-1:0] : base + qf[PIX_W-1:0];
    end

    // store write and read selection
    always_comb begin
        grad_we = 1'b0;
        grad_wa = cnt_reg;
        grad_wd = '0;
        grad_ra = (state_reg == ST_IDLE) ? {req.slice_index, req.row, req.column} : p2_addr;
        if (state_reg == ST_CLEAR) begin
            grad_we = 1'b1;
        end else if (state_reg == ST_ACC_ADD && axis_reg == 2'd2) begin
            grad_we = 1'b1;
            grad_wd = acc_sum;
        end else if (state_reg == ST_OUT_DIV && flat) begin
            grad_we = 1'b1;
            grad_wa = p2_addr;
            grad_wd = {cfg.out_min[PIX_W-1], cfg.out_min};
        end else if (state_reg == ST_OUT_WAIT && div_resp.done) begin
            grad_we = 1'b1;
            grad_wa = p2_addr;
            grad_wd = {res[PIX_W-1], res};
        end
    end

    // pixel memory, one write and two reads
    always_ff @(posedge aclk) begin
        if (req.valid && req.kind == REQ_LOAD) begin
            vol_mem[{req.slice_index, req.row, req.column}] <= req.pixel_value;
        end
        vol_a_reg <= vol_mem[vol_ra_a];
        vol_b_reg <= vol_mem[vol_ra_b];
    end

    // gradient memory, one write and one read
    always_ff @(posedge aclk) begin
        if (grad_we) begin
            grad_mem[grad_wa] <= grad_wd;
        end
        grad_rd_reg <= grad_mem[grad_ra];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (&cnt_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (req.valid) begin
                        unique case (req.kind)
                            REQ_READ: state_reg <= ST_RD_WAIT;
                            REQ_COMPUTE: begin
                                cnt_reg   <= '0;
                                axis_reg  <= 2'd0;
                                acc_reg   <= '0;
                                state_reg <= ST_ACC_RD;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RD_WAIT: state_reg <= ST_IDLE;
                ST_ACC_RD: begin
                    term_en_reg <= axis_ok;
                    state_reg   <= ST_ACC_ADD;
                end
                ST_ACC_ADD: begin
                    if (axis_reg == 2'd2) begin
                        acc_reg  <= '0;
                        axis_reg <= 2'd0;
                        cnt_reg  <= cnt_reg + 1'b1;
                        if (&cnt_reg) begin
                            slice_reg <= '0;
                            state_reg <= ST_SLICE;
                        end else begin
                            state_reg <= ST_ACC_RD;
                        end
                    end else begin
                        acc_reg   <= acc_sum;
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= ST_ACC_RD;
                    end
                end
                ST_SLICE: begin
                    row_reg   <= '0;
                    col_reg   <= '0;
                    first_reg <= 1'b1;
                    if (slice_reg < sc_lim && w_lim != '0 && h_lim != '0) begin
                        state_reg <= cfg.rescale_enable ? ST_MM_RD : ST_OUT_RD;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_MM_RD: state_reg <= ST_MM_CMP;
                ST_MM_CMP: begin
                    first_reg <= 1'b0;
                    if (first_reg || grad_rd_reg < lo_reg) begin
                        lo_reg <= grad_rd_reg;
                    end
                    if (first_reg || grad_rd_reg > hi_reg) begin
                        hi_reg <= grad_rd_reg;
                    end
                    col_reg <= col_last ? '0 : col_reg + 1'b1;
                    if (col_last) begin
                        row_reg <= row_last ? '0 : row_reg + 1'b1;
                    end
                    state_reg <= pass_end ? ST_OUT_RD : ST_MM_RD;
                end
                ST_OUT_RD: state_reg <= ST_OUT_MUL;
                ST_OUT_MUL: begin
                    v_reg     <= grad_rd_reg;
                    prod_reg  <= prod_next;
                    state_reg <= ST_OUT_DIV;
                end
                ST_OUT_DIV: begin
                    neg_reg <= num_neg;
                    if (flat) begin
                        col_reg <= col_last ? '0 : col_reg + 1'b1;
                        if (col_last) begin
                            row_reg <= row_last ? '0 : row_reg + 1'b1;
                        end
                        if (pass_end) begin
                            slice_reg <= slice_reg + 1'b1;
                            state_reg <= ST_SLICE;
                        end else begin
                            state_reg <= ST_OUT_RD;
                        end
                    end else begin
                        state_reg <= ST_OUT_WAIT;
                    end
                end
                ST_OUT_WAIT: begin
                    if (div_resp.done) begin
                        col_reg <= col_last ? '0 : col_reg + 1'b1;
                        if (col_last) begin
                            row_reg <= row_last ? '0 : row_reg + 1'b1;
                        end
                        if (pass_end) begin
                            slice_reg <= slice_reg + 1'b1;
                            state_reg <= ST_SLICE;
                        end else begin
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                ST_DONE: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign ready       = (state_reg == ST_IDLE);
    assign resp.valid  = (state_reg == ST_RD_WAIT) || (state_reg == ST_DONE);
    assign resp.value  = (state_reg == ST_RD_WAIT) ? grad_rd_reg[PIX_W-1:0] : '0;

    `ASSERT_PROP(a_div_done_in_wait, div_resp.done |-> state_reg == ST_OUT_WAIT, "divider result outside wait")
    `ASSERT_NEXT(a_read_goes_wait, req.valid && ready && req.kind == REQ_READ, state_reg == ST_RD_WAIT, "read not answered next cycle")
    `ASSERT_PROP(a_resp_when_busy, resp.valid |-> !ready, "result while idle")

endmodule
`default_nettype wire

FILE: src/volume_central_difference_gradient.sv
// Central difference gradient magnitude over a small volume of 16-bit pixels.
// Input words arrive on the s_axis channel: tuser carries the request kind
// (load, compute, read), tdata the pixel address and the value to load.
// Every input word yields exactly one output word on m_axis: tdata holds the
// stored result for reads and zero otherwise, tuser echoes the request kind.
// Loads and unknown kinds go straight to the output register; reads first
// pass a registered memory read. A compute runs a sequencer over the whole
// 65536-entry store: the accumulate pass reads and adds each axis of every
// entry in turn, then the configured pixels go through the bit-serial
// divider, after a min/max scan per slice when rescaling is on. s_axis_tready
// stays low meanwhile. After reset a clearing pass zeroes the result store;
// no input word is accepted during it, configuration writes are always taken.
// A stalled receiver holds the output word; a new input word is taken only
// when the output register is empty or being emptied in the same cycle.
`default_nettype none
`include "volume_central_difference_gradient_macros.svh"
module volume_central_difference_gradient
    import vcdg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // slice_index[1:0], column[8:2], row[15:9], pixel_value[31:16]
    input  wire logic [31:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result_value[15:0]
    output logic [15:0]      m_axis_tdata,
    // request_kind[1:0]
    output logic [1:0]       m_axis_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t      cfg_reg;
    eng_req_t  eng_req;
    eng_resp_t eng_resp;
    logic      eng_ready;

    logic             m_valid_reg;
    logic [PIX_W-1:0] m_data_reg;
    req_kind_t        m_kind_reg;
    req_kind_t        pend_kind_reg;
    logic             s_accept;

    // register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width    <= 8'd128;
            cfg_reg.image_height   <= 8'd128;
            cfg_reg.slice_count    <= 3'd4;
            cfg_reg.axis_mask      <= 3'd1;
            cfg_reg.step_distance  <= 6'd1;
            cfg_reg.rescale_enable <= 1'b0;
            cfg_reg.out_min        <= 16'sd0;
            cfg_reg.out_max        <= 16'sd32767;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_data[7:0];
                CFG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_data[7:0];
                CFG_SLICE_COUNT:    cfg_reg.slice_count    <= cfg_data[2:0];
                CFG_AXIS_MASK:      cfg_reg.axis_mask      <= cfg_data[2:0];
                CFG_STEP_DISTANCE:  cfg_reg.step_distance  <= cfg_data[5:0];
                CFG_RESCALE_ENABLE: cfg_reg.rescale_enable <= cfg_data[0];
                CFG_OUT_MIN:        cfg_reg.out_min        <= cfg_data;
                CFG_OUT_MAX:        cfg_reg.out_max        <= cfg_data;
            endcase
        end
    end

    // input word acceptance
    assign s_axis_tready = eng_ready && (!m_valid_reg || m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        eng_req.valid       = s_accept;
        eng_req.kind        = req_kind_t'(s_axis_tuser);
        eng_req.slice_index = s_axis_tdata[1:0];
        eng_req.column      = s_axis_tdata[8:2];
        eng_req.row         = s_axis_tdata[15:9];
        eng_req.pixel_value = s_axis_tdata[31:16];
    end

    vcdg_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .req     (eng_req),
        .ready   (eng_ready),
        .resp    (eng_resp)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                pend_kind_reg <= req_kind_t'(s_axis_tuser);
            end
            if (s_accept && (s_axis_tuser == REQ_LOAD || s_axis_tuser == REQ_NONE)) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= '0;
                m_kind_reg  <= req_kind_t'(s_axis_tuser);
            end else if (eng_resp.valid) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= eng_resp.value;
                m_kind_reg  <= pend_kind_reg;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_kind_reg;

    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
    `ASSERT_NEXT(a_load_answer, s_accept && s_axis_tuser == REQ_LOAD, m_valid_reg && m_kind_reg == REQ_LOAD, "load not answered")
    `ASSERT_PROP(a_no_overrun, eng_resp.valid |-> !m_valid_reg, "result over a waiting word")

endmodule
`default_nettype wire

FILE: test/volume_central_difference_gradient_tb.sv
`default_nettype none
module volume_central_difference_gradient_tb;
    import vcdg_pkg::*;

    localparam int READ_SPAN  = 150;
    localparam int ITEM_GOAL  = 2000;
    localparam int LONG_HOLD  = 400;

    // one row of the directed stimulus table
    typedef struct {
        req_kind_t   kind;
        logic [1:0]  slc;
        logic [6:0]  col;
        logic [6:0]  row;
        logic [15:0] pix;
        bit          typed;
        logic [15:0] typed_val;
    } stim_row_t;

    typedef struct {
        logic [15:0] value;
        logic [1:0]  kind;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // shadow of the block state
    logic signed [15:0] vol_mem [DEPTH];
    int                 grad_mem [DEPTH];
    cfg_t               shadow_cfg;
    int                 eff_w, eff_h, eff_sc;

    answer_t answer_q [$];
    int      errors;
    int      n_items, n_loads, n_reads, n_computes, n_unknown, n_cfg;
    bit      calm;
    int      hold_tickets, hold_served;

    stim_row_t directed_rows [9];
    cfg_t      directed_cfgs [6];

    volume_central_difference_gradient dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit, computes walk the whole store many times
    initial begin
        #400000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int cell_idx(int s, int r, int c);
        return (s * MAX_HEIGHT + r) * MAX_WIDTH + c;
    endfunction

    function automatic int clamp_dim(int v, int m);
        return (v > m) ? m : v;
    endfunction

    // absolute neighbour difference, clamped
    function automatic int diff_term(int a, int b);
        int d;
        d = int'(vol_mem[a]) - int'(vol_mem[b]);
        if (d < 0) d = -d;
        return (d > 32767) ? 32767 : d;
    endfunction

    function automatic longint div_floor(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    // gradient magnitude over the configured volume
    function automatic void gradient_pass();
        int     d, m, acc, a;
        longint n, lo, hi, v, res, span, omin, omax;
        d = shadow_cfg.step_distance;
        m = shadow_cfg.axis_mask;
        n = m[0] + m[1] + m[2];
        if (n == 0) n = 1;
        omin = longint'($signed(shadow_cfg.out_min));
        omax = longint'($signed(shadow_cfg.out_max));
        for (int i = 0; i < DEPTH; i++) grad_mem[i] = 0;
        for (int s = 0; s < eff_sc; s++)
            for (int r = 0; r < eff_h; r++)
                for (int c = 0; c < eff_w; c++) begin
                    acc = 0;
                    if (m[0] && c >= d && c + d < eff_w)
                        acc += diff_term(cell_idx(s, r, c + d), cell_idx(s, r, c - d));
                    if (m[1] && r >= d && r + d < eff_h)
                        acc += diff_term(cell_idx(s, r + d, c), cell_idx(s, r - d, c));
                    if (m[2] && s >= d && s + d < eff_sc)
                        acc += diff_term(cell_idx(s + d, r, c), cell_idx(s - d, r, c));
                    grad_mem[cell_idx(s, r, c)] = acc;
                end
        if (eff_w == 0 || eff_h == 0) return;
        for (int s = 0; s < eff_sc; s++) begin
            lo = grad_mem[cell_idx(s, 0, 0)];
            hi = lo;
            for (int r = 0; r < eff_h; r++)
                for (int c = 0; c < eff_w; c++) begin
                    v = grad_mem[cell_idx(s, r, c)];
                    if (v < lo) lo = v;
                    if (v > hi) hi = v;
                end
            for (int r = 0; r < eff_h; r++)
                for (int c = 0; c < eff_w; c++) begin
                    a = cell_idx(s, r, c);
                    v = grad_mem[a];
                    if (!shadow_cfg.rescale_enable) begin
                        res = (2 * v + n) / (2 * n);
                    end else if (hi == lo) begin
                        res = omin;
                    end else begin
                        span = hi - lo;
                        res = omin + div_floor(2 * (omax - omin) * (v - lo) + span, 2 * span);
                    end
                    grad_mem[a] = int'(res);
                end
        end
    endfunction

    // state update and answer for one accepted word
    function automatic logic [15:0] predict_answer(req_kind_t k, int s, int c, int r,
                                                   logic [15:0] pix);
        case (k)
            REQ_LOAD: begin
                vol_mem[cell_idx(s, r, c)] = pix;
                return 16'h0;
            end
            REQ_COMPUTE: begin
                gradient_pass();
                return 16'h0;
            end
            REQ_READ: return grad_mem[cell_idx(s, r, c)][15:0];
            default:  return 16'h0;
        endcase
    endfunction

    function automatic int pick_gap();
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // result checker
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                $error("unexpected result word: value %h kind %0d", m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                e = answer_q.pop_front();
                if (m_axis_tdata !== e.value) begin
                    $error("result_value: expected %h, got %h", e.value, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== e.kind) begin
                    $error("request_kind: expected %0d, got %0d", e.kind, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // receiver, random stalls and the long hold-off
    initial begin
        int run_len, gap;
        m_axis_tready = 1'b0;
        forever begin
            if (hold_tickets != hold_served) begin
                hold_served++;
                repeat (LONG_HOLD) begin
                    m_axis_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
            run_len = $urandom_range(1, 20);
            repeat (run_len) begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
            gap = pick_gap();
            repeat (gap) begin
                m_axis_tready <= 1'b0;
                @(posedge aclk);
            end
        end
    end

    // stop offering and wait for every expected word
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
    endtask

    // one input word, expectation recorded at acceptance
    task automatic send_word(req_kind_t k, logic [1:0] s, logic [6:0] c, logic [6:0] r,
                             logic [15:0] pix, bit typed, logic [15:0] typed_val);
        int          gap;
        answer_t     e;
        logic [15:0] pred;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pix, r, c, s};
        s_axis_tuser  <= k;
        do @(posedge aclk); while (!s_axis_tready);
        pred = predict_answer(k, s, c, r, pix);
        e.value = typed ? typed_val : pred;
        e.kind  = k;
        answer_q.push_back(e);
        n_items++;
        case (k)
            REQ_LOAD:    n_loads++;
            REQ_COMPUTE: n_computes++;
            REQ_READ:    n_reads++;
            default:     n_unknown++;
        endcase
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH:    shadow_cfg.image_width    = val[7:0];
            CFG_IMAGE_HEIGHT:   shadow_cfg.image_height   = val[7:0];
            CFG_SLICE_COUNT:    shadow_cfg.slice_count    = val[2:0];
            CFG_AXIS_MASK:      shadow_cfg.axis_mask      = val[2:0];
            CFG_STEP_DISTANCE:  shadow_cfg.step_distance  = val[5:0];
            CFG_RESCALE_ENABLE: shadow_cfg.rescale_enable = val[0];
            CFG_OUT_MIN:        shadow_cfg.out_min        = val;
            default:            shadow_cfg.out_max        = val;
        endcase
        n_cfg++;
    endtask

    task automatic apply_config(cfg_t c);
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 16'(c.image_width));
        write_reg(CFG_IMAGE_HEIGHT, 16'(c.image_height));
        write_reg(CFG_SLICE_COUNT, 16'(c.slice_count));
        write_reg(CFG_AXIS_MASK, 16'(c.axis_mask));
        write_reg(CFG_STEP_DISTANCE, 16'(c.step_distance));
        write_reg(CFG_RESCALE_ENABLE, 16'(c.rescale_enable));
        write_reg(CFG_OUT_MIN, c.out_min);
        write_reg(CFG_OUT_MAX, c.out_max);
        cfg_valid <= 1'b0;
        eff_w  = clamp_dim(shadow_cfg.image_width, MAX_WIDTH);
        eff_h  = clamp_dim(shadow_cfg.image_height, MAX_HEIGHT);
        eff_sc = clamp_dim(shadow_cfg.slice_count, MAX_SLICES);
    endtask

    // random word, reads mostly in the configured volume
    task automatic send_random();
        int p;
        bit in_vol;
        p = $urandom_range(0, 99);
        in_vol = (eff_w > 0 && eff_h > 0 && eff_sc > 0 && $urandom_range(0, 9) < 7);
        if (p < 45)
            send_word(REQ_LOAD, 2'($urandom), 7'($urandom), 7'($urandom), pick_pixel(), 0, 0);
        else if (p < 93 && in_vol)
            send_word(REQ_READ, 2'($urandom_range(0, eff_sc - 1)),
                      7'($urandom_range(0, eff_w - 1)), 7'($urandom_range(0, eff_h - 1)),
                      16'($urandom), 0, 0);
        else if (p < 93)
            send_word(REQ_READ, 2'($urandom), 7'($urandom), 7'($urandom), 16'($urandom), 0, 0);
        else
            send_word(REQ_NONE, 2'($urandom), 7'($urandom), 7'($urandom), 16'($urandom), 0, 0);
    endtask

    // configure, fill the volume, mix, compute, read back
    task automatic run_phase(cfg_t c, int n_mix, bit squeeze);
        int total, pause_at;
        apply_config(c);
        for (int s = 0; s < eff_sc; s++)
            for (int r = 0; r < eff_h; r++)
                for (int x = 0; x < eff_w; x++)
                    send_word(REQ_LOAD, 2'(s), 7'(x), 7'(r), pick_pixel(), 0, 0);
        pause_at = $urandom_range(0, n_mix);
        for (int i = 0; i < n_mix; i++) begin
            if (i == pause_at) begin
                if (squeeze) hold_tickets++;
                else wait_drained();
            end
            send_random();
        end
        send_word(REQ_COMPUTE, 2'($urandom), 7'($urandom), 7'($urandom), 16'($urandom), 0, 0);
        total = eff_w * eff_h * eff_sc;
        if (total <= READ_SPAN) begin
            for (int s = 0; s < eff_sc; s++)
                for (int r = 0; r < eff_h; r++)
                    for (int x = 0; x < eff_w; x++)
                        send_word(REQ_READ, 2'(s), 7'(x), 7'(r), 16'($urandom), 0, 0);
        end else begin
            repeat (READ_SPAN)
                send_word(REQ_READ, 2'($urandom_range(0, eff_sc - 1)),
                          7'($urandom_range(0, eff_w - 1)), 7'($urandom_range(0, eff_h - 1)),
                          16'($urandom), 0, 0);
        end
        repeat (20) send_random();
    endtask

    // main sequence
    initial begin
        cfg_t rc;
        int   phase;
        errors = 0;
        n_items = 0; n_loads = 0; n_reads = 0; n_computes = 0; n_unknown = 0; n_cfg = 0;
        hold_tickets = 0; hold_served = 0;
        calm = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            vol_mem[i]  = '0;
            grad_mem[i] = 0;
        end
        shadow_cfg = '{8'd128, 8'd128, 3'd4, 3'd1, 6'd1, 1'b0, 16'sd0, 16'sd32767};
        eff_w = 128; eff_h = 128; eff_sc = 4;

        // nothing computed yet, so every read answers zero
        directed_rows = '{
            '{REQ_READ,    2'd0, 7'd0,    7'd0,    16'h0000, 1, 16'h0},
            '{REQ_READ,    2'd3, 7'd127,  7'd127,  16'hffff, 1, 16'h0},
            '{REQ_NONE,    2'd3, 7'd127,  7'd127,  16'hffff, 1, 16'h0},
            '{REQ_LOAD,    2'd0, 7'd0,    7'd0,    16'h8000, 1, 16'h0},
            '{REQ_LOAD,    2'd3, 7'd127,  7'd127,  16'h7fff, 1, 16'h0},
            '{REQ_LOAD,    2'd2, 7'h55,   7'h2a,   16'hffff, 1, 16'h0},
            '{REQ_LOAD,    2'd1, 7'h2a,   7'h55,   16'h0000, 1, 16'h0},
            '{REQ_READ,    2'd2, 7'h55,   7'h2a,   16'h0000, 1, 16'h0},
            '{REQ_NONE,    2'd0, 7'd0,    7'd0,    16'h0000, 1, 16'h0}
        };
        // full axis mask, clamped sizes and an oversized step, reversed range, empty width,
        // empty mask with a flat slice
        directed_cfgs = '{
            '{8'd3,   8'd3,   3'd3, 3'd7, 6'd1,  1'b0, 16'sd0,     16'sd32767},
            '{8'd200, 8'd1,   3'd1, 3'd1, 6'd63, 1'b1, -16'sd32768, 16'sd32767},
            '{8'd1,   8'd255, 3'd1, 3'd2, 6'd1,  1'b1, 16'sd32767, -16'sd32768},
            '{8'd4,   8'd4,   3'd7, 3'd4, 6'd1,  1'b0, 16'sd0,     16'sd32767},
            '{8'd0,   8'd5,   3'd2, 3'd0, 6'd2,  1'b1, -16'sd100,  16'sd100},
            '{8'd5,   8'd5,   3'd2, 3'd0, 6'd1,  1'b1, -16'sd100,  16'sd100}
        };

        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].kind, directed_rows[i].slc, directed_rows[i].col,
                      directed_rows[i].row, directed_rows[i].pix, directed_rows[i].typed,
                      directed_rows[i].typed_val);

        phase = 0;
        foreach (directed_cfgs[i]) begin
            calm = (phase % 3 == 2);
            run_phase(directed_cfgs[i], 40, phase == 1);
            phase++;
        end

        // random geometry, mostly small
        while (n_items < ITEM_GOAL) begin
            calm = (phase % 4 == 3);
            rc.image_width    = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
            rc.image_height   = 8'($urandom_range(1, 8));
            rc.slice_count    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                             : 3'($urandom_range(1, 4));
            rc.axis_mask      = 3'($urandom);
            case ($urandom_range(0, 9))
                0:       rc.step_distance = 6'($urandom);
                1, 2:    rc.step_distance = 6'($urandom_range(2, 3));
                default: rc.step_distance = 6'd1;
            endcase
            rc.rescale_enable = 1'($urandom);
            rc.out_min        = 16'($urandom);
            rc.out_max        = 16'($urandom);
            run_phase(rc, 150, phase % 3 == 0);
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("covered %0d words: %0d loads, %0d reads, %0d computes, %0d unknown kinds",
                 n_items, n_loads, n_reads, n_computes, n_unknown);
        $display("over %0d register writes in %0d settings, %0d mismatches",
                 n_cfg, phase, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
